// ===== sv/rrsp_pkg.sv =====
// ----------------------------------------------------------------------------
// rrsp_pkg
// Shared widths, pipeline types and the exp table builder for the
// rounded-rect spotlight pixel unit.
// ----------------------------------------------------------------------------
package rrsp_pkg;

  localparam int COORD_BITS      = 12;
  localparam int EXP_TABLE_DEPTH = 1024;
  localparam int LOG2D           = $clog2(EXP_TABLE_DEPTH);

  // signed working width of coordinate differences
  localparam int SW   = COORD_BITS + 3;
  // corner distance width (unsigned)
  localparam int DW   = COORD_BITS + 1;
  localparam int SUMW = 2 * DW + 1;
  localparam int QW   = 2 * SW - 1;

  // iterative section: sqrt and divide spread over ITER_STAGES stages
  localparam int ITER_STAGES = 4;
  localparam int SQ_STEPS    = 16;
  localparam int SQ_PER      = SQ_STEPS / ITER_STAGES;
  localparam int DV_PER      = (LOG2D + ITER_STAGES - 1) / ITER_STAGES;
  localparam int DVS         = DV_PER * ITER_STAGES;
  localparam int NW          = 16 + LOG2D;

  localparam int IN_BITS  = 6 * COORD_BITS + 14;
  localparam int IN_TDATA = ((IN_BITS + 7) / 8) * 8;

  localparam logic [2:0] REG_GLOW_COLOR      = 3'd0;
  localparam logic [2:0] REG_GLOW_STRENGTH   = 3'd1;
  localparam logic [2:0] REG_BORDER_STRENGTH = 3'd2;
  localparam logic [2:0] REG_BORDER_TENTHS   = 3'd3;
  localparam logic [2:0] REG_SPREAD          = 3'd4;
  localparam logic [2:0] REG_CORNER_RADIUS   = 3'd5;

  typedef struct packed {
    logic [23:0] color;
    logic [7:0]  glow;
    logic [7:0]  border;
    logic [7:0]  tenths;
    logic [15:0] spread;   // already forced nonzero
    logic [7:0]  radius;
  } cfg_t;

  typedef struct packed {
    logic           dfar;
    logic           gfar;
    logic [7:0]     op;
    logic [17:0]    srem;
    logic [15:0]    root;
    logic [31:0]    rad;
    logic [16:0]    drem;
    logic [DVS-1:0] quo;
    logic [DVS-1:0] nb;
  } pipe_t;

  typedef logic [16:0] exp_rom_t [EXP_TABLE_DEPTH];

  function automatic exp_rom_t build_exp_rom();
    exp_rom_t    rom;
    logic [63:0] t;
    logic [63:0] term;
    logic [63:0] ratio;
    logic [63:0] e30;
    t     = (64'd16 << 32) / EXP_TABLE_DEPTH;
    term  = 64'd1 << 32;
    ratio = 64'd1 << 32;
    e30   = 64'd1 << 30;
    for (int n = 1; n <= 10; n++) begin
      term = ((term * t) >> 32) / 64'(n);
      if (n % 2 == 1) ratio = ratio - term;
      else ratio = ratio + term;
    end
    ratio = ratio >> 2;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      rom[i] = 17'((e30 + 64'd8192) >> 14);
      e30    = (e30 * ratio) >> 30;
    end
    return rom;
  endfunction

endpackage

// ===== sv/rrsp_geom.sv =====
// ----------------------------------------------------------------------------
// rrsp_geom
// Two stages: corner and pointer offsets, then squared distances and the
// start values of the sqrt and divide iterations.
// ----------------------------------------------------------------------------
module rrsp_geom import rrsp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [COORD_BITS-1:0] pixel_x,
  input  logic [COORD_BITS-1:0] pixel_y,
  input  logic [COORD_BITS:0]   width,
  input  logic [COORD_BITS:0]   height,
  input  logic [COORD_BITS+1:0] pointer_x,
  input  logic [COORD_BITS+1:0] pointer_y,
  input  logic [7:0]            master_opacity,
  input  cfg_t                  cfg,
  output logic                  out_valid,
  output pipe_t                 out
);

  logic                 v1;
  logic [DW-1:0]        dx, dy;
  logic signed [SW-1:0] ex, ey;
  logic [7:0]           op1;

  logic [DW-1:0]        dx_next, dy_next;
  logic signed [SW-1:0] ex_next, ey_next;

  function automatic logic [DW-1:0] core_dist(logic [COORD_BITS-1:0] p,
                                              logic [COORD_BITS:0] size,
                                              logic [7:0] r);
    logic signed [SW-1:0] a;
    logic signed [SW-1:0] b;
    logic signed [SW-1:0] m;
    a = $signed(SW'(r)) - $signed(SW'(p));
    b = $signed(SW'(p)) - $signed(SW'(size)) + $signed(SW'(r));
    m = (a > b) ? a : b;
    return (m > 0) ? m[DW-1:0] : '0;
  endfunction

  always_comb begin
    dx_next = core_dist(pixel_x, width, cfg.radius);
    dy_next = core_dist(pixel_y, height, cfg.radius);
    ex_next = $signed(SW'(pixel_x)) - $signed({pointer_x[COORD_BITS+1], pointer_x});
    ey_next = $signed(SW'(pixel_y)) - $signed({pointer_y[COORD_BITS+1], pointer_y});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      dx  <= dx_next;
      dy  <= dy_next;
      ex  <= ex_next;
      ey  <= ey_next;
      op1 <= master_opacity;
    end
  end

  logic [SUMW-1:0]        sum;
  logic signed [2*SW-1:0] ex2, ey2;
  logic [QW-1:0]          q2;
  logic [NW-1:0]          num;
  pipe_t                  init;

  always_comb begin
    sum = SUMW'(dx * dx) + SUMW'(dy * dy);
    ex2 = ex * ex;
    ey2 = ey * ey;
    q2  = {1'b0, ex2[2*SW-3:0]} + {1'b0, ey2[2*SW-3:0]};
    num = {q2[19:0], {(LOG2D-4){1'b0}}};
    init.dfar = |sum[SUMW-1:16];
    init.gfar = q2 >= QW'({cfg.spread, 4'b0000});
    init.op   = op1;
    init.srem = '0;
    init.root = '0;
    init.rad  = {sum[15:0], 16'h0000};
    init.drem = 17'(num[NW-1:DVS]);
    init.quo  = '0;
    init.nb   = num[DVS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
    if (en) begin
      out <= init;
    end
  end

endmodule

// ===== sv/rrsp_iter.sv =====
// ----------------------------------------------------------------------------
// rrsp_iter
// One stage of the iterative section: a few restoring sqrt steps for the
// corner distance and a few restoring divide steps for the exp index.
// ----------------------------------------------------------------------------
module rrsp_iter import rrsp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  pipe_t in,
  input  cfg_t  cfg,
  output logic  out_valid,
  output pipe_t out
);

  pipe_t       nxt;
  logic [19:0] rem2;
  logic [17:0] trial;
  logic [17:0] r2;

  always_comb begin
    nxt = in;
    for (int i = 0; i < SQ_PER; i++) begin
      rem2  = {nxt.srem, nxt.rad[31:30]};
      trial = {nxt.root, 2'b01};
      if (rem2 >= 20'(trial)) begin
        nxt.srem = 18'(rem2 - 20'(trial));
        nxt.root = {nxt.root[14:0], 1'b1};
      end else begin
        nxt.srem = rem2[17:0];
        nxt.root = {nxt.root[14:0], 1'b0};
      end
      nxt.rad = {nxt.rad[29:0], 2'b00};
    end
    for (int k = 0; k < DV_PER; k++) begin
      r2 = {nxt.drem, nxt.nb[DVS-1]};
      if (r2 >= 18'(cfg.spread)) begin
        r2      = r2 - 18'(cfg.spread);
        nxt.quo = {nxt.quo[DVS-2:0], 1'b1};
      end else begin
        nxt.quo = {nxt.quo[DVS-2:0], 1'b0};
      end
      nxt.drem = r2[16:0];
      nxt.nb   = {nxt.nb[DVS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out <= nxt;
    end
  end

endmodule

// ===== sv/rrsp_shade.sv =====
// ----------------------------------------------------------------------------
// rrsp_shade
// Exp table read, glow/border select with edge fade, opacity scaling and
// the premultiplied color channels, ending in the output register.
// ----------------------------------------------------------------------------
module rrsp_shade import rrsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  pipe_t       in,
  input  cfg_t        cfg,
  output logic        out_valid,
  output logic [31:0] out_data
);

  localparam exp_rom_t EXP_ROM = build_exp_rom();

  // stage A: table read
  logic        va;
  logic [16:0] rom_q;
  logic        glow_ok, dfar_a;
  logic [15:0] d_a;
  logic [7:0]  op_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= in_valid;
    end
    if (en) begin
      rom_q   <= EXP_ROM[in.quo[LOG2D-1:0]];
      glow_ok <= !in.gfar;
      dfar_a  <= in.dfar;
      d_a     <= in.root;
      op_a    <= in.op;
    end
  end

  // stage B: max of terms and fade mask
  logic [24:0]        glow;
  logic [23:0]        border, m_next;
  logic [15:0]        rfx, diff;
  logic [19:0]        lhs;
  logic signed [21:0] rhs;
  logic               inside_r, band;
  logic [8:0]         mask_next;

  always_comb begin
    glow     = glow_ok ? 25'(rom_q * cfg.glow) : '0;
    rfx      = {cfg.radius, 8'h00};
    inside_r = !dfar_a && (d_a <= rfx);
    lhs      = 20'(d_a * 10);
    rhs      = $signed({2'b00, 20'(cfg.radius * 12'd2560)})
             - $signed({6'b0, cfg.tenths, 8'h00});
    band     = inside_r && ($signed({2'b00, lhs}) >= rhs);
    border   = band ? {cfg.border, 16'h0000} : '0;
    m_next   = (glow > 25'(border)) ? glow[23:0] : border;
    diff     = d_a - rfx;
    if (dfar_a) mask_next = '0;
    else if (inside_r) mask_next = 9'd256;
    else if (diff >= 16'd256) mask_next = '0;
    else mask_next = 9'(16'd256 - diff);
  end

  logic        vb;
  logic [23:0] m_b;
  logic [8:0]  mask_b, mask_c;
  logic [7:0]  op_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
    if (en) begin
      m_b    <= m_next;
      mask_b <= mask_next;
      op_b   <= op_a;
    end
  end

  // stage C, D: two multiplies
  logic        vc, vd;
  logic [31:0] p_c;
  logic [40:0] p2;
  logic [16:0] t_d;

  assign p2 = 41'(p_c * mask_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
      vd <= 1'b0;
    end else if (en) begin
      vc <= vb;
      vd <= vc;
    end
    if (en) begin
      p_c    <= 32'(m_b * op_b);
      mask_c <= mask_b;
      t_d    <= p2[40:24];
    end
  end

  // stage E: alpha = t / 255 with clamp; div255 is exact for t below 65280
  function automatic logic [7:0] div255(logic [15:0] x);
    logic [16:0] s;
    s = 17'(x) + 17'(x >> 8) + 17'd1;
    return s[15:8];
  endfunction

  logic       ve;
  logic [7:0] a_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else if (en) begin
      ve <= vd;
    end
    if (en) begin
      a_e <= (t_d >= 17'd65280) ? 8'd255 : div255(t_d[15:0]);
    end
  end

  // stage F: channels, output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ve;
    end
    if (en) begin
      out_data <= {div255(16'(a_e * cfg.color[7:0])),
                   div255(16'(a_e * cfg.color[15:8])),
                   div255(16'(a_e * cfg.color[23:16])),
                   a_e};
    end
  end

endmodule

// ===== sv/rounded_rect_spotlight_pixel_unit.sv =====
// ----------------------------------------------------------------------------
// rounded_rect_spotlight_pixel_unit
// Per-pixel premultiplied ARGB for a rounded-rect overlay with a pointer
// spotlight and a border band.
// ----------------------------------------------------------------------------
// channel   dir  handshake               payload
// s_axis    in   s_tvalid / s_tready     pixel, size, pointer, opacity
// m_axis    out  m_tvalid / m_tready     alpha, red, green, blue
// cfg       in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One pixel per clock sustained unless the output stalls; a pixel passes
// through geometry, the 4-stage sqrt/divide section and the shade/multiply chain.
// rst (sync) clears all valid bits and loads the register reset values.
// When m_tvalid is held without m_tready the whole pipeline freezes and
// s_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module rounded_rect_spotlight_pixel_unit import rrsp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // pixel_x, pixel_y, width, height, pointer_x, pointer_y, master_opacity
  input  logic [IN_TDATA-1:0] s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // alpha, red, green, blue
  output logic [31:0]         m_tdata,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_data
);

  localparam int CB = COORD_BITS;

  logic [23:0] glow_color;
  logic [7:0]  glow_strength, border_strength, border_tenths, corner_radius;
  logic [15:0] spread;
  cfg_t        cfg;
  logic        en;

  assign cfg_ready = !rst;
  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      glow_color      <= 24'hFFFFFF;
      glow_strength   <= 8'd120;
      border_strength <= 8'd255;
      border_tenths   <= 8'd15;
      spread          <= 16'd350;
      corner_radius   <= 8'd6;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GLOW_COLOR:      glow_color      <= cfg_data;
        REG_GLOW_STRENGTH:   glow_strength   <= cfg_data[7:0];
        REG_BORDER_STRENGTH: border_strength <= cfg_data[7:0];
        REG_BORDER_TENTHS:   border_tenths   <= cfg_data[7:0];
        REG_SPREAD:          spread          <= cfg_data[15:0];
        REG_CORNER_RADIUS:   corner_radius   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.color  = glow_color;
    cfg.glow   = glow_strength;
    cfg.border = border_strength;
    cfg.tenths = border_tenths;
    cfg.spread = (spread == 16'd0) ? 16'd1 : spread;
    cfg.radius = corner_radius;
  end

  logic  v_st [ITER_STAGES+1];
  pipe_t p_st [ITER_STAGES+1];

  rrsp_geom u_geom (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_valid       (s_tvalid),
    .pixel_x        (s_tdata[CB-1:0]),
    .pixel_y        (s_tdata[2*CB-1:CB]),
    .width          (s_tdata[3*CB:2*CB]),
    .height         (s_tdata[4*CB+1:3*CB+1]),
    .pointer_x      (s_tdata[5*CB+3:4*CB+2]),
    .pointer_y      (s_tdata[6*CB+5:5*CB+4]),
    .master_opacity (s_tdata[6*CB+13:6*CB+6]),
    .cfg            (cfg),
    .out_valid      (v_st[0]),
    .out            (p_st[0])
  );

  for (genvar g = 0; g < ITER_STAGES; g++) begin : g_iter
    rrsp_iter u_iter (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (v_st[g]),
      .in        (p_st[g]),
      .cfg       (cfg),
      .out_valid (v_st[g+1]),
      .out       (p_st[g+1])
    );
  end

  rrsp_shade u_shade (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_st[ITER_STAGES]),
    .in        (p_st[ITER_STAGES]),
    .cfg       (cfg),
    .out_valid (m_tvalid),
    .out_data  (m_tdata)
  );

`ifndef SYNTHESIS
  a_ready_follows_stall : assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("s_tready does not track output stall");

  a_zero_alpha_black : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[7:0] == 8'd0) |-> (m_tdata[31:8] == 24'd0))
    else $error("color nonzero with zero alpha");

  a_chan_below_alpha : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:8] <= m_tdata[7:0]) && (m_tdata[23:16] <= m_tdata[7:0])
                 && (m_tdata[31:24] <= m_tdata[7:0]))
    else $error("premultiplied channel exceeds alpha");
`endif

endmodule

// ===== tb/tb_rounded_rect_spotlight_pixel_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rounded_rect_spotlight_pixel_unit
// Drives pixels through the spotlight unit and checks every ARGB beat
// against a local fixed-point predictor, across several register settings
// and three idling patterns on the two streams.
// ----------------------------------------------------------------------------
module tb_rounded_rect_spotlight_pixel_unit;
  import rrsp_pkg::*;

  localparam int TABLE_N  = EXP_TABLE_DEPTH;
  localparam int CYC_MAX  = 600000;
  localparam int DRAIN    = 40;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [7:0]  opacity;
    logic [13:0] ptr_y;
    logic [13:0] ptr_x;
    logic [12:0] hgt;
    logic [12:0] wid;
    logic [11:0] py;
    logic [11:0] px;
  } pixel_t;

  typedef struct packed {
    logic [7:0] blu;
    logic [7:0] grn;
    logic [7:0] red;
    logic [7:0] alp;
  } argb_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0, s_tready;
  logic [IN_TDATA-1:0] s_tdata = '0;
  logic m_tvalid, m_tready = 0;
  logic [31:0] m_tdata;
  logic cfg_valid = 0, cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  rounded_rect_spotlight_pixel_unit u_dut (.*);

  initial forever #5 clk = ~clk;

  // local copy of the register file
  logic [23:0] tint;
  logic [7:0]  glow_amp, band_amp, band_tenths, corner_r;
  logic [15:0] glow_spread;
  logic [63:0] exp_tab [TABLE_N];

  argb_t pending_argb [$];
  int fails = 0, cycles = 0, beats_in = 0, beats_out = 0;
  int s_idle_pct = 0, m_idle_pct = 0;

  task automatic make_exp_table();
    logic [63:0] t, term, ratio, e30;
    t = (64'd16 << 32) / TABLE_N;
    term = 64'd1 << 32;
    ratio = 64'd1 << 32;
    e30 = 64'd1 << 30;
    for (int n = 1; n <= 10; n++) begin
      term = ((term * t) >> 32) / 64'(n);
      if (n % 2) ratio -= term;
      else ratio += term;
    end
    ratio >>= 2;
    for (int i = 0; i < TABLE_N; i++) begin
      exp_tab[i] = (e30 + 64'd8192) >> 14;
      e30 = (e30 * ratio) >> 30;
    end
  endtask

  function automatic longint corner_off(longint p, longint sz, longint r);
    longint a, b, m;
    a = r - p;
    b = p - (sz - r);
    m = a > b ? a : b;
    return m > 0 ? m : 0;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v -= res + bt;
        res = (res >> 1) + bt;
      end else res >>= 1;
      bt >>= 2;
    end
    return res;
  endfunction

  function automatic argb_t shade_pixel(pixel_t p);
    longint r, dx, dy, ex, ey;
    logic [63:0] d, q2, s, idx, glow, band, m, mask, a, rfx;
    argb_t o;
    r = longint'(corner_r);
    dx = corner_off(longint'(p.px), longint'(p.wid), r);
    dy = corner_off(longint'(p.py), longint'(p.hgt), r);
    d = int_sqrt(64'(dx * dx + dy * dy) << 16);
    if (d > 64'hFFFFF) d = 64'hFFFFF;
    ex = longint'(p.px) - longint'($signed(p.ptr_x));
    ey = longint'(p.py) - longint'($signed(p.ptr_y));
    q2 = 64'(ex * ex) + 64'(ey * ey);
    s = (glow_spread != 0) ? 64'(glow_spread) : 64'd1;
    idx = (q2 * TABLE_N) / (16 * s);
    glow = idx < TABLE_N ? exp_tab[idx] * 64'(glow_amp) : 64'd0;
    rfx = 64'(r << 8);
    band = (longint'(10 * d) >= 2560 * r - 256 * longint'(band_tenths) && d <= rfx)
           ? 64'(band_amp) << 16 : 64'd0;
    if (d <= rfx) mask = 64'd256;
    else if (d - rfx >= 256) mask = 64'd0;
    else mask = 64'd256 - (d - rfx);
    m = glow > band ? glow : band;
    a = (m * 64'(p.opacity) * mask) / (64'd255 * 65536 * 256);
    if (a > 255) a = 64'd255;
    o.alp = 8'(a);
    o.red = 8'((a * 64'(tint[23:16])) / 255);
    o.grn = 8'((a * 64'(tint[15:8])) / 255);
    o.blu = 8'((a * 64'(tint[7:0])) / 255);
    return o;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_GLOW_COLOR:      tint = val;
      REG_GLOW_STRENGTH:   glow_amp = val[7:0];
      REG_BORDER_STRENGTH: band_amp = val[7:0];
      REG_BORDER_TENTHS:   band_tenths = val[7:0];
      REG_SPREAD:          glow_spread = val[15:0];
      REG_CORNER_RADIUS:   corner_r = val[7:0];
      default: ;
    endcase
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 0;
    while (pending_argb.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // one beat; expectation pushed when accepted. typed result checked against it too if given
  // tvalid stays up after the accept so the next beat can follow at once;
  // wait_idle drops it
  task automatic send_pixel(pixel_t p, bit has_typed = 0, argb_t typed = '0);
    argb_t e;
    while ($urandom_range(99) < s_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= IN_TDATA'(p);
    do @(posedge clk); while (!s_tready);
    e = shade_pixel(p);
    if (has_typed && e != typed) begin
      $display("%0t predictor row: expected %h actual %h", $time, typed, e);
      fails++;
    end
    pending_argb.push_back(e);
    beats_in++;
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t p;
    int w, h;
    if ($urandom_range(9) < 8) begin
      // mostly small overlays so corners, band and spotlight are all hit
      w = $urandom_range(1, 64);
      h = $urandom_range(1, 64);
      p.wid = 13'(w);
      p.hgt = 13'(h);
      p.px = 12'($urandom_range(0, w + 2));
      p.py = 12'($urandom_range(0, h + 2));
      p.ptr_x = 14'($urandom_range(0, 80) - 8);
      p.ptr_y = 14'($urandom_range(0, 80) - 8);
    end else begin
      p.wid = 13'($urandom_range(0, 8191));
      p.hgt = 13'($urandom_range(0, 8191));
      p.px = 12'($urandom);
      p.py = 12'($urandom);
      p.ptr_x = 14'($urandom);
      p.ptr_y = 14'($urandom);
    end
    p.opacity = $urandom_range(3) == 0 ? 8'd255 : 8'($urandom);
    return p;
  endfunction

  // receiver and checker
  always @(posedge clk) begin
    argb_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        beats_out++;
        if (pending_argb.size() == 0) begin
          $display("%0t unexpected beat: expected none actual %h", $time, got);
          fails++;
        end else begin
          want = pending_argb.pop_front();
          if (got.alp != want.alp) begin
            $display("%0t alpha: expected %0d actual %0d", $time, want.alp, got.alp);
            fails++;
          end
          if (got.red != want.red) begin
            $display("%0t red: expected %0d actual %0d", $time, want.red, got.red);
            fails++;
          end
          if (got.grn != want.grn) begin
            $display("%0t green: expected %0d actual %0d", $time, want.grn, got.grn);
            fails++;
          end
          if (got.blu != want.blu) begin
            $display("%0t blue: expected %0d actual %0d", $time, want.blu, got.blu);
            fails++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= m_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYC_MAX) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  typedef struct {
    pixel_t p;
    bit     typed;
    argb_t  res;
  } row_t;

  row_t rows [$];

  function automatic pixel_t pix(int x, int y, int w, int h, int ptx, int pty, int op);
    pixel_t p;
    p.px = 12'(x); p.py = 12'(y); p.wid = 13'(w); p.hgt = 13'(h);
    p.ptr_x = 14'(ptx); p.ptr_y = 14'(pty); p.opacity = 8'(op);
    return p;
  endfunction

  initial begin
    int phase_items;
    tint = 24'hFFFFFF; glow_amp = 8'd120; band_amp = 8'd255; band_tenths = 8'd15;
    glow_spread = 16'd350; corner_r = 8'd6;
    make_exp_table();
    // reset values; rows marked typed carry hand-derived results
    rows.push_back('{pix(50, 50, 100, 100, 50, 50, 0), 1, '0});        // zero opacity
    rows.push_back('{pix(50, 50, 100, 100, 50, 50, 255), 0, '0});      // spotlight peak
    rows.push_back('{pix(0, 0, 100, 100, 4000, 4000, 255), 1, '0});    // far corner, faded
    rows.push_back('{pix(50, 0, 100, 100, 2000, 2000, 255), 1, '{8'd255, 8'd255, 8'd255, 8'd255}}); // top edge band
    rows.push_back('{pix(50, 1, 100, 100, -8192, 8191, 255), 0, '0});
    rows.push_back('{pix(4095, 4095, 4096, 4096, 8191, -8192, 255), 0, '0});
    rows.push_back('{pix(4095, 4095, 0, 0, 0, 0, 255), 1, '0});        // zero size, far
    rows.push_back('{pix(5, 5, 1, 1, 5, 5, 200), 0, '0});
    rows.push_back('{pix(4095, 0, 8191, 8191, -1, -1, 128), 0, '0});
    rows.push_back('{pix(2, 2, 100, 100, 2, 2, 255), 0, '0});          // inside corner arc
    rows.push_back('{pix(1, 1, 100, 100, 60, 60, 255), 0, '0});
    rows.push_back('{pix(0, 50, 10, 100, 0, 50, 255), 0, '0});
    rows.push_back('{pix(2730, 1365, 2730, 1365, 1365, 2730, 170), 0, '0});
    rows.push_back('{pix(1365, 2730, 4096, 4096, -2731, 5461, 85), 0, '0});

    repeat (8) @(posedge clk);
    rst <= 0;
    m_tready <= 1;
    @(posedge clk);
    foreach (rows[i]) send_pixel(rows[i].p, rows[i].typed, rows[i].res);
    wait_idle();

    // extremes of every register, plus a write to an unused index
    write_reg(REG_SPREAD, 24'd0);
    write_reg(REG_CORNER_RADIUS, 24'd0);
    write_reg(REG_BORDER_TENTHS, 24'd255);
    write_reg(REG_UNUSED, 24'hABCDEF);
    send_pixel(pix(3, 3, 10, 10, 3, 3, 255));
    send_pixel(pix(0, 0, 10, 10, 1, 0, 255));
    wait_idle();
    write_reg(REG_GLOW_COLOR, 24'h000000);
    write_reg(REG_GLOW_STRENGTH, 24'd255);
    write_reg(REG_BORDER_STRENGTH, 24'd0);
    write_reg(REG_SPREAD, 24'hFFFF);
    write_reg(REG_CORNER_RADIUS, 24'd255);
    send_pixel(pix(100, 100, 4096, 4096, 100, 100, 255));
    send_pixel(pix(0, 0, 4096, 4096, 8191, 8191, 255));
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_GLOW_COLOR, 24'($urandom));
      write_reg(REG_GLOW_STRENGTH, 24'($urandom_range(0, 255)));
      write_reg(REG_BORDER_STRENGTH, 24'($urandom_range(0, 255)));
      write_reg(REG_BORDER_TENTHS, ph == 5 ? 24'd0 : 24'($urandom_range(0, 120)));
      write_reg(REG_SPREAD, ph == 0 ? 24'd1 : 24'($urandom_range(1, 4000)));
      write_reg(REG_CORNER_RADIUS, ph == 1 ? 24'd1 : 24'($urandom_range(0, 20)));
      s_idle_pct = (ph < 2) ? 6 : (ph < 4) ? 48 : 0;
      m_idle_pct = (ph < 2) ? 48 : (ph < 4) ? 6 : 0;
      phase_items = 195;
      for (int k = 0; k < phase_items; k++) begin
        send_pixel(rand_pixel());
        // occasional stretch of back-to-back beats
        if ($urandom_range(40) == 0) begin
          int keep_s;
          keep_s = s_idle_pct;
          s_idle_pct = 0;
          repeat (20) send_pixel(rand_pixel());
          s_idle_pct = keep_s;
        end
      end
      wait_idle();
    end

    m_idle_pct = 0;
    wait_idle();
    $display("%0d pixels sent, %0d results checked over 9 register settings", beats_in,
             beats_out);
    $display("three idling patterns on input and output streams");
    if (fails == 0 && pending_argb.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
